// ===== hw/rtl/vtr_pkg.sv =====
// Package with payload types, sequencer states and the reset radius for the trackball core.
package vtr_pkg;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] x_pos;
        logic signed [15:0] y_pos;
    } vtr_in_t;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic        [14:0] point_z;
    } vtr_out_t;

    localparam logic [14:0] RADIUS_RESET = 15'd11469;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PROJ,
        ST_PROJ_SQ,
        ST_PROJ_DIV,
        ST_PROJ_END,
        ST_CROSS,
        ST_CROSS_SHR,
        ST_NORM_SUM,
        ST_NORM_SQ,
        ST_AXIS_DIV,
        ST_DIST_SUM,
        ST_DIST_SQ,
        ST_LEN_DIV,
        ST_RW_SQ,
        ST_RV_MUL,
        ST_QUAT,
        ST_OUT
    } vtr_state_t;

endpackage

// ===== hw/rtl/virtual_trackball_rotation_core.sv =====
// Top level of the virtual trackball rotation core with its sequencer and shared units.
//
// Usage: an input transfer on in_valid/in_ready carries cmd, x_pos and y_pos.
// A start (cmd 0) lifts the pointer onto the sphere or hyperbolic sheet and
// stores the point. A drag (cmd 1) builds an incremental rotation from the
// stored point to the new one and premultiplies it onto the held quaternion.
// Every input transfer gives exactly one output transfer on out_valid/out_ready
// with the quaternion after the step and the lifted height of the pointer.
// The radius is written through cfg_valid/cfg_ready while the core is idle.
//
// The sequencer works through the shared multiplier, one product per cycle,
// and the shared restoring square root and divider, one result bit per cycle
// while busy (32 steps per root, 64 per divide, three divides for the axis).
// One item is in flight at a time; in_ready is low meanwhile and returns when
// the sequencer goes from its output state back to idle on the output transfer.
// The output register holds the result until it is taken, so a stalled
// receiver only holds the core in its output state; nothing is lost.
// Reset clears the stored point to zero and the quaternion to identity,
// and the radius to 0.7 in unsigned Q1.14.
module virtual_trackball_rotation_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  vtr_pkg::vtr_in_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output vtr_pkg::vtr_out_t out_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [14:0]     cfg_data
);
    import vtr_pkg::*;

    vtr_state_t state_reg, state_next;
    logic [14:0] radius_reg;
    logic        cmd_reg;
    logic signed [15:0] x_reg, y_reg, z_reg;
    logic signed [15:0] lpx_reg, lpy_reg, lpz_reg;
    logic signed [15:0] rw_reg, rx_reg, ry_reg, rz_reg;
    logic [14:0] pz_out_reg;
    // Wide scratch registers.
    logic signed [63:0] acc_reg;
    logic signed [63:0] c_reg [3];
    logic [63:0] m_reg [3];
    logic signed [15:0] ax_reg [3];
    logic signed [15:0] rv_reg [3];
    logic signed [15:0] len_reg, rwq_reg;
    logic [63:0] nrm_reg;
    logic [4:0]  step_reg;
    logic [2:0]  idx_reg;

    // Shared iterative square root and divider.
    logic [63:0] sq_rem_reg, sq_res_reg, sq_bit_reg;
    logic [63:0] dv_num_reg, dv_den_reg, dv_q_reg, dv_r_reg;
    logic [6:0]  dv_cnt_reg;
    logic        sq_busy, dv_busy;

    // Shared multiplier.
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;
    assign mul_p = mul_a * mul_b;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign out_data  = '{quat_w: rw_reg, quat_x: rx_reg, quat_y: ry_reg, quat_z: rz_reg,
                         point_z: pz_out_reg};
    assign sq_busy = (sq_bit_reg != 64'd0);
    assign dv_busy = (dv_cnt_reg != 7'd0);

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        mag64 = v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        logic signed [63:0] f;
        f = v >>> 14;
        if (f > 64'sd32767) sat16 = 16'sh7fff;
        else if (f < -64'sd32768) sat16 = 16'sh8000;
        else sat16 = f[15:0];
    endfunction

    // Multiplier operand selection per step.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_PROJ:
            begin
                unique case (step_reg[1:0])
                    2'd0:    begin mul_a = 34'(radius_reg); mul_b = 34'(radius_reg); end
                    2'd1:    begin mul_a = 34'(x_reg); mul_b = 34'(x_reg); end
                    default: begin mul_a = 34'(y_reg); mul_b = 34'(y_reg); end
                endcase
            end
            ST_CROSS:
            begin
                unique case (step_reg[2:0])
                    3'd0:    begin mul_a = 34'(y_reg); mul_b = 34'(lpz_reg); end
                    3'd1:    begin mul_a = 34'(z_reg); mul_b = 34'(lpy_reg); end
                    3'd2:    begin mul_a = 34'(z_reg); mul_b = 34'(lpx_reg); end
                    3'd3:    begin mul_a = 34'(x_reg); mul_b = 34'(lpz_reg); end
                    3'd4:    begin mul_a = 34'(x_reg); mul_b = 34'(lpy_reg); end
                    default: begin mul_a = 34'(y_reg); mul_b = 34'(lpx_reg); end
                endcase
            end
            ST_NORM_SUM:
            begin
                mul_a = $signed({1'b0, m_reg[idx_reg[1:0]][32:0]});
                mul_b = $signed({1'b0, m_reg[idx_reg[1:0]][32:0]});
            end
            ST_DIST_SUM:
            begin
                unique case (idx_reg[1:0])
                    2'd0:    begin mul_a = 34'(lpx_reg) - 34'(x_reg); end
                    2'd1:    begin mul_a = 34'(lpy_reg) - 34'(y_reg); end
                    default: begin mul_a = 34'(lpz_reg) - 34'(z_reg); end
                endcase
                mul_b = mul_a;
            end
            ST_RW_SQ:
            begin
                mul_a = 34'(len_reg);
                mul_b = 34'(len_reg);
            end
            ST_RV_MUL:
            begin
                mul_a = 34'(ax_reg[idx_reg[1:0]][15] ? -ax_reg[idx_reg[1:0]]
                                                      : ax_reg[idx_reg[1:0]]);
                mul_b = 34'(len_reg);
            end
            ST_QUAT:
            begin
                // 16 products: row idx (w,x,y,z), term step.
                unique case ({idx_reg[1:0], step_reg[1:0]})
                    4'h0: begin mul_a = 34'(rwq_reg);   mul_b = 34'(rw_reg); end
                    4'h1: begin mul_a = -34'(rv_reg[0]); mul_b = 34'(rx_reg); end
                    4'h2: begin mul_a = -34'(rv_reg[1]); mul_b = 34'(ry_reg); end
                    4'h3: begin mul_a = -34'(rv_reg[2]); mul_b = 34'(rz_reg); end
                    4'h4: begin mul_a = 34'(rwq_reg);   mul_b = 34'(rx_reg); end
                    4'h5: begin mul_a = 34'(rv_reg[0]); mul_b = 34'(rw_reg); end
                    4'h6: begin mul_a = 34'(rv_reg[1]); mul_b = 34'(rz_reg); end
                    4'h7: begin mul_a = -34'(rv_reg[2]); mul_b = 34'(ry_reg); end
                    4'h8: begin mul_a = 34'(rwq_reg);   mul_b = 34'(ry_reg); end
                    4'h9: begin mul_a = 34'(rv_reg[1]); mul_b = 34'(rw_reg); end
                    4'ha: begin mul_a = 34'(rv_reg[2]); mul_b = 34'(rx_reg); end
                    4'hb: begin mul_a = -34'(rv_reg[0]); mul_b = 34'(rz_reg); end
                    4'hc: begin mul_a = 34'(rwq_reg);   mul_b = 34'(rz_reg); end
                    4'hd: begin mul_a = 34'(rv_reg[2]); mul_b = 34'(rw_reg); end
                    4'he: begin mul_a = 34'(rv_reg[0]); mul_b = 34'(ry_reg); end
                    default: begin mul_a = -34'(rv_reg[1]); mul_b = 34'(rx_reg); end
                endcase
            end
            default: ;
        endcase
    end

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (in_valid) state_next = ST_PROJ;
            ST_PROJ:      if (step_reg == 5'd2) state_next = ST_PROJ_SQ;
            ST_PROJ_SQ:   if (!sq_busy && step_reg == 5'd1) state_next = ST_PROJ_DIV;
            ST_PROJ_DIV:  if (!dv_busy && step_reg == 5'd1) state_next = ST_PROJ_END;
            ST_PROJ_END:
            begin
                if (cmd_reg && (x_reg != lpx_reg || y_reg != lpy_reg))
                    state_next = ST_CROSS;
                else
                    state_next = ST_OUT;
            end
            ST_CROSS:     if (step_reg == 5'd5) state_next = ST_CROSS_SHR;
            ST_CROSS_SHR: if (m_reg[0] < 64'h4000_0000 && m_reg[1] < 64'h4000_0000 &&
                              m_reg[2] < 64'h4000_0000) state_next = ST_NORM_SUM;
            ST_NORM_SUM:  if (idx_reg == 3'd2) state_next = ST_NORM_SQ;
            ST_NORM_SQ:   if (!sq_busy && step_reg == 5'd1) state_next = ST_AXIS_DIV;
            ST_AXIS_DIV:  if (!dv_busy && step_reg == 5'd1 && idx_reg == 3'd2)
                              state_next = ST_DIST_SUM;
            ST_DIST_SUM:  if (idx_reg == 3'd2) state_next = ST_DIST_SQ;
            ST_DIST_SQ:   if (!sq_busy && step_reg == 5'd1) state_next = ST_LEN_DIV;
            ST_LEN_DIV:   if (!dv_busy && step_reg == 5'd1) state_next = ST_RW_SQ;
            ST_RW_SQ:     if (!sq_busy && step_reg == 5'd1) state_next = ST_RV_MUL;
            ST_RV_MUL:    if (idx_reg == 3'd2) state_next = ST_QUAT;
            ST_QUAT:      if (idx_reg == 3'd3 && step_reg == 5'd3) state_next = ST_OUT;
            ST_OUT:       if (out_ready) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Datapath. Multi-cycle units use step_reg 0 to launch, 1 to collect.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
            lpx_reg <= '0;
            lpy_reg <= '0;
            lpz_reg <= '0;
            rw_reg  <= 16'sd16384;
            rx_reg  <= '0;
            ry_reg  <= '0;
            rz_reg  <= '0;
            step_reg <= '0;
            idx_reg  <= '0;
            sq_bit_reg <= '0;
            dv_cnt_reg <= '0;
        end
        else
        begin
            // Square root: one result bit per cycle.
            if (sq_busy)
            begin
                if (sq_rem_reg >= sq_res_reg + sq_bit_reg)
                begin
                    sq_rem_reg <= sq_rem_reg - (sq_res_reg + sq_bit_reg);
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                    sq_res_reg <= sq_res_reg >> 1;
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            // Divider: one quotient bit per cycle, 64 steps max.
            if (dv_busy)
            begin
                if ({dv_r_reg[62:0], dv_num_reg[63]} >= dv_den_reg)
                begin
                    dv_r_reg <= {dv_r_reg[62:0], dv_num_reg[63]} - dv_den_reg;
                    dv_q_reg <= {dv_q_reg[62:0], 1'b1};
                end
                else
                begin
                    dv_r_reg <= {dv_r_reg[62:0], dv_num_reg[63]};
                    dv_q_reg <= {dv_q_reg[62:0], 1'b0};
                end
                dv_num_reg <= dv_num_reg << 1;
                dv_cnt_reg <= dv_cnt_reg - 7'd1;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cfg_valid)
                        radius_reg <= cfg_data;
                    if (in_valid)
                    begin
                        cmd_reg <= in_data.cmd;
                        x_reg <= in_data.x_pos;
                        y_reg <= in_data.y_pos;
                        step_reg <= '0;
                    end
                end
                ST_PROJ:
                begin
                    // c_reg[0] = r^2, acc = d^2.
                    if (step_reg == 5'd0) c_reg[0] <= mul_p[63:0];
                    else if (step_reg == 5'd1) acc_reg <= mul_p[63:0];
                    else acc_reg <= acc_reg + mul_p[63:0];
                    step_reg <= (step_reg == 5'd2) ? 5'd0 : step_reg + 5'd1;
                end
                ST_PROJ_SQ:
                begin
                    if (step_reg == 5'd0)
                    begin
                        // Sphere: sqrt(r^2-d^2); sheet: sqrt(d^2).
                        sq_rem_reg <= (acc_reg < ((c_reg[0] + 64'sd1) >>> 1))
                                      ? 64'(c_reg[0] - acc_reg) : 64'(acc_reg);
                        sq_res_reg <= '0;
                        sq_bit_reg <= 64'h4000_0000_0000_0000;
                        step_reg <= 5'd1;
                    end
                    else if (!sq_busy)
                        step_reg <= 5'd0;
                end
                ST_PROJ_DIV:
                begin
                    if (step_reg == 5'd0)
                    begin
                        dv_num_reg <= 64'(c_reg[0]);
                        dv_den_reg <= {sq_res_reg[62:0], 1'b0};
                        dv_r_reg <= '0;
                        // On the sheet a zero distance keeps the root, which is zero.
                        if (acc_reg >= ((c_reg[0] + 64'sd1) >>> 1) && sq_res_reg != 64'd0)
                        begin
                            dv_q_reg <= '0;
                            dv_cnt_reg <= 7'd64;
                        end
                        else
                            dv_q_reg <= sq_res_reg;
                        step_reg <= 5'd1;
                    end
                    else if (!dv_busy)
                        step_reg <= 5'd0;
                end
                ST_PROJ_END:
                begin
                    z_reg <= (dv_q_reg > 64'd32767) ? 16'sd32767 : $signed({1'b0, dv_q_reg[14:0]});
                    pz_out_reg <= (dv_q_reg > 64'd32767) ? 15'h7fff : dv_q_reg[14:0];
                    if (!cmd_reg)
                    begin
                        lpx_reg <= x_reg;
                        lpy_reg <= y_reg;
                        lpz_reg <= (dv_q_reg > 64'd32767) ? 16'sd32767
                                   : $signed({1'b0, dv_q_reg[14:0]});
                    end
                end
                ST_CROSS:
                begin
                    unique case (step_reg[2:0]) inside
                        3'd0, 3'd2, 3'd4: acc_reg <= mul_p[63:0];
                        default:
                        begin
                            c_reg[step_reg[2:1]] <= acc_reg - mul_p[63:0];
                            m_reg[step_reg[2:1]] <= mag64(acc_reg - mul_p[63:0]);
                        end
                    endcase
                    step_reg <= (step_reg == 5'd5) ? 5'd0 : step_reg + 5'd1;
                    idx_reg <= '0;
                end
                ST_CROSS_SHR:
                begin
                    if (!(m_reg[0] < 64'h4000_0000 && m_reg[1] < 64'h4000_0000 &&
                          m_reg[2] < 64'h4000_0000))
                    begin
                        m_reg[0] <= m_reg[0] >> 1;
                        m_reg[1] <= m_reg[1] >> 1;
                        m_reg[2] <= m_reg[2] >> 1;
                    end
                end
                ST_NORM_SUM:
                begin
                    acc_reg <= (idx_reg == 3'd0) ? mul_p[63:0] : acc_reg + mul_p[63:0];
                    idx_reg <= (idx_reg == 3'd2) ? 3'd0 : idx_reg + 3'd1;
                end
                ST_NORM_SQ:
                begin
                    if (step_reg == 5'd0)
                    begin
                        sq_rem_reg <= 64'(acc_reg);
                        sq_res_reg <= '0;
                        sq_bit_reg <= 64'h4000_0000_0000_0000;
                        step_reg <= 5'd1;
                    end
                    else if (!sq_busy)
                    begin
                        nrm_reg <= sq_res_reg;
                        step_reg <= 5'd0;
                    end
                end
                ST_AXIS_DIV:
                begin
                    if (step_reg == 5'd0)
                    begin
                        dv_num_reg <= m_reg[idx_reg[1:0]] << 14;
                        dv_den_reg <= nrm_reg;
                        dv_r_reg <= '0;
                        dv_q_reg <= '0;
                        if (nrm_reg != 64'd0) dv_cnt_reg <= 7'd64;
                        step_reg <= 5'd1;
                    end
                    else if (!dv_busy)
                    begin
                        ax_reg[idx_reg[1:0]] <= c_reg[idx_reg[1:0]][63]
                                                ? -dv_q_reg[15:0] : dv_q_reg[15:0];
                        step_reg <= 5'd0;
                        idx_reg <= (idx_reg == 3'd2) ? 3'd0 : idx_reg + 3'd1;
                    end
                end
                ST_DIST_SUM:
                begin
                    acc_reg <= (idx_reg == 3'd0) ? mul_p[63:0] : acc_reg + mul_p[63:0];
                    idx_reg <= (idx_reg == 3'd2) ? 3'd0 : idx_reg + 3'd1;
                end
                ST_DIST_SQ:
                begin
                    if (step_reg == 5'd0)
                    begin
                        sq_rem_reg <= 64'(acc_reg);
                        sq_res_reg <= '0;
                        sq_bit_reg <= 64'h4000_0000_0000_0000;
                        step_reg <= 5'd1;
                    end
                    else if (!sq_busy)
                        step_reg <= 5'd0;
                end
                ST_LEN_DIV:
                begin
                    if (step_reg == 5'd0)
                    begin
                        dv_num_reg <= sq_res_reg << 14;
                        dv_den_reg <= 64'(radius_reg) << 1;
                        dv_r_reg <= '0;
                        dv_q_reg <= (sq_res_reg != 64'd0) ? 64'd16384 : 64'd0;
                        if (radius_reg != 15'd0) dv_cnt_reg <= 7'd64;
                        step_reg <= 5'd1;
                    end
                    else if (!dv_busy)
                    begin
                        len_reg <= (dv_q_reg > 64'd16384) ? 16'sd16384 : $signed(dv_q_reg[15:0]);
                        step_reg <= 5'd0;
                    end
                end
                ST_RW_SQ:
                begin
                    if (step_reg == 5'd0)
                    begin
                        sq_rem_reg <= 64'd268435456 - 64'(mul_p[31:0]);
                        sq_res_reg <= '0;
                        sq_bit_reg <= 64'h4000_0000_0000_0000;
                        step_reg <= 5'd1;
                    end
                    else if (!sq_busy)
                    begin
                        rwq_reg <= sq_res_reg[15:0];
                        step_reg <= 5'd0;
                    end
                end
                ST_RV_MUL:
                begin
                    rv_reg[idx_reg[1:0]] <= ax_reg[idx_reg[1:0]][15]
                                            ? -mul_p[29:14] : mul_p[29:14];
                    idx_reg <= (idx_reg == 3'd2) ? 3'd0 : idx_reg + 3'd1;
                end
                ST_QUAT:
                begin
                    // Accumulate one row; store all rows at the end so old values feed all.
                    if (step_reg == 5'd0)
                        acc_reg <= mul_p[63:0];
                    else if (step_reg != 5'd3)
                        acc_reg <= acc_reg + mul_p[63:0];
                    else
                        c_reg[idx_reg[1:0] == 2'd3 ? 2'd0 : idx_reg[1:0]] <= '0;
                    if (step_reg == 5'd3)
                    begin
                        unique case (idx_reg[1:0])
                            2'd0:    m_reg[0] <= 64'(acc_reg + mul_p[63:0]);
                            2'd1:    m_reg[1] <= 64'(acc_reg + mul_p[63:0]);
                            2'd2:    m_reg[2] <= 64'(acc_reg + mul_p[63:0]);
                            default:
                            begin
                                rw_reg <= sat16($signed(m_reg[0]));
                                rx_reg <= sat16($signed(m_reg[1]));
                                ry_reg <= sat16($signed(m_reg[2]));
                                rz_reg <= sat16(acc_reg + mul_p[63:0]);
                                lpx_reg <= x_reg;
                                lpy_reg <= y_reg;
                                lpz_reg <= z_reg;
                            end
                        endcase
                        idx_reg <= idx_reg + 3'd1;
                        step_reg <= 5'd0;
                    end
                    else
                        step_reg <= step_reg + 5'd1;
                end
                default: ;
            endcase
        end
    end

    // Only one item is in flight: input and output never both handshake.
    assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("input and output open together");
    // A result held for a stalled receiver does not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result changed under stall");
    // Each accepted input leaves idle on the next edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("core stayed idle after transfer");

endmodule
